// ===== design/aegis128l_pkg.sv =====
// ----------------------------------------------------------------------------
// aegis128l_pkg
// Shared types, mode codes, the AES S-box and xtime for the AEGIS-128L core.
// ----------------------------------------------------------------------------
package aegis128l_pkg;

    localparam int NUM_BLOCKS  = 8;
    localparam int BLOCK_W     = 128;
    localparam int WORD_W      = 64;
    localparam int BLK_IDX_W   = 3;
    localparam int MODE_W      = 3;
    localparam int CHUNK_BYTES = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ABSORB     = 3'd0,
        MODE_ENCRYPT    = 3'd1,
        MODE_DECRYPT    = 3'd2,
        MODE_STREAM     = 3'd3,
        MODE_STREAM_XOR = 3'd4,
        MODE_LOAD       = 3'd5,
        MODE_READ       = 3'd6,
        MODE_UNUSED     = 3'd7
    } t_mode;

    typedef logic [BLOCK_W-1:0]                 t_block;
    typedef logic [NUM_BLOCKS-1:0][BLOCK_W-1:0] t_state;

    // One result transfer.
    typedef struct packed {
        logic [WORD_W-1:0] out_w3;
        logic [WORD_W-1:0] out_w2;
        logic [WORD_W-1:0] out_w1;
        logic [WORD_W-1:0] out_w0;
    } t_result;

    // What the merge stage hands back to the top level.
    typedef struct packed {
        logic    has_result;
        logic    do_update;
        t_block  fb_m0;
        t_block  fb_m1;
        t_result result;
    } t_merge;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Multiply by x in GF(2^8), AES polynomial.
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== design/aegis128l_in_if.sv =====
// ----------------------------------------------------------------------------
// aegis128l_in_if
// Input channel: one 32-byte chunk with its mode and block index.
// ----------------------------------------------------------------------------
interface aegis128l_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [63:0] in_w0;
    logic [63:0] in_w1;
    logic [63:0] in_w2;
    logic [63:0] in_w3;
    logic [2:0]  block_index;

    modport source (output valid, mode, in_w0, in_w1, in_w2, in_w3, block_index,
                    input ready);
    modport sink   (input valid, mode, in_w0, in_w1, in_w2, in_w3, block_index,
                    output ready);
endinterface

// ===== design/aegis128l_out_if.sv =====
// ----------------------------------------------------------------------------
// aegis128l_out_if
// Output channel: one 32-byte result.
// ----------------------------------------------------------------------------
interface aegis128l_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_w0;
    logic [63:0] out_w1;
    logic [63:0] out_w2;
    logic [63:0] out_w3;

    modport source (output valid, out_w0, out_w1, out_w2, out_w3, input ready);
    modport sink   (input valid, out_w0, out_w1, out_w2, out_w3, output ready);
endinterface

// ===== design/aegis128l_lane.sv =====
// ----------------------------------------------------------------------------
// aegis128l_lane
// One state lane: AES round of the previous block, xor own block and message.
// ----------------------------------------------------------------------------
module aegis128l_lane
    import aegis128l_pkg::*;
(
    input  t_block i_src,
    input  t_block i_self,
    input  t_block i_msg,
    output t_block o_next
);

    t_block w_round;

    always_comb begin
        logic [7:0] sb [16];
        logic [7:0] a0, a1, a2, a3;
        // SubBytes with ShiftRows folded into the source index
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[r + 4*c] = SBOX[i_src[8*(r + 4*((c + r) % 4)) +: 8]];
            end
        end
        // MixColumns
        for (int c = 0; c < 4; c++) begin
            a0 = sb[4*c];
            a1 = sb[4*c + 1];
            a2 = sb[4*c + 2];
            a3 = sb[4*c + 3];
            w_round[8*(4*c)     +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            w_round[8*(4*c + 1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            w_round[8*(4*c + 2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            w_round[8*(4*c + 3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
    end

    assign o_next = w_round ^ i_self ^ i_msg;

endmodule

// ===== design/aegis128l_merge.sv =====
// ----------------------------------------------------------------------------
// aegis128l_merge
// Keystream, result word and lane feedback selection per mode.
// ----------------------------------------------------------------------------
module aegis128l_merge
    import aegis128l_pkg::*;
(
    input  t_state      i_state,
    input  logic [2:0]  i_mode,
    input  t_block      i_m0,
    input  t_block      i_m1,
    output t_merge      o_merge
);

    t_block w_z0, w_z1, w_r0, w_r1;

    // keystream comes from the state before the update
    assign w_z0 = i_state[1] ^ i_state[6] ^ (i_state[2] & i_state[3]);
    assign w_z1 = i_state[2] ^ i_state[5] ^ (i_state[6] & i_state[7]);

    assign w_r0 = (i_mode == MODE_STREAM) ? w_z0 : (i_m0 ^ w_z0);
    assign w_r1 = (i_mode == MODE_STREAM) ? w_z1 : (i_m1 ^ w_z1);

    always_comb begin
        o_merge.result     = {w_r1, w_r0};
        o_merge.fb_m0      = '0;
        o_merge.fb_m1      = '0;
        o_merge.has_result = 1'b0;
        o_merge.do_update  = 1'b0;
        case (i_mode)
            MODE_ABSORB: begin
                o_merge.fb_m0     = i_m0;
                o_merge.fb_m1     = i_m1;
                o_merge.do_update = 1'b1;
            end
            MODE_ENCRYPT: begin
                o_merge.fb_m0      = i_m0;
                o_merge.fb_m1      = i_m1;
                o_merge.do_update  = 1'b1;
                o_merge.has_result = 1'b1;
            end
            MODE_DECRYPT: begin
                o_merge.fb_m0      = w_r0;
                o_merge.fb_m1      = w_r1;
                o_merge.do_update  = 1'b1;
                o_merge.has_result = 1'b1;
            end
            MODE_STREAM, MODE_STREAM_XOR: begin
                o_merge.do_update  = 1'b1;
                o_merge.has_result = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/aegis128l_skid.sv =====
// ----------------------------------------------------------------------------
// aegis128l_skid
// Two-entry output buffer: main register plus skid register.
// ----------------------------------------------------------------------------
module aegis128l_skid
    import aegis128l_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_result         i_data,
    output logic            o_ready,
    aegis128l_out_if.source o_out
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop   = r_main_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || w_pop) begin
            if (r_skid_valid) begin
                // drain skid first; no push can arrive while it is full
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_data;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out.valid  = r_main_valid;
    assign o_out.out_w0 = r_main.out_w0;
    assign o_out.out_w1 = r_main.out_w1;
    assign o_out.out_w2 = r_main.out_w2;
    assign o_out.out_w3 = r_main.out_w3;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without a main entry");

    a_stall_keeps_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !o_out.ready) |=> (r_main_valid && r_main == $past(r_main)))
        else $error("stalled result changed");

    a_push_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_valid && !o_out.ready) |=> r_skid_valid)
        else $error("result pushed during stall was dropped");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push into full buffer");

endmodule

// ===== design/aegis128l_stream_core_unit.sv =====
// ----------------------------------------------------------------------------
// aegis128l_stream_core_unit
// AEGIS-128L stream core, 8 x 128-bit state: one 32-byte chunk a cycle if ready.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | transfer when
//  i_in    | in  | mode, in_w0..in_w3, block_index           | valid && ready
//  o_out   | out | out_w0..out_w3                            | valid && ready
//
//  One chunk is taken per cycle while i_in.ready is high; the state update
//  (eight AES rounds, one per lane, in parallel) completes in the same cycle,
//  so back-to-back chunks chain through the state register. Results are
//  registered. Synchronous active-low reset clears the state to all zeros and
//  empties the output buffer. i_in.ready drops only when both output entries
//  are full, i.e. after two results have waited on a stalled o_out.
// ----------------------------------------------------------------------------
module aegis128l_stream_core_unit
    import aegis128l_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    aegis128l_in_if.sink    i_in,
    aegis128l_out_if.source o_out
);

    t_state  r_state;
    t_state  w_lane_next;
    t_block  w_m0, w_m1, w_load;
    t_merge  w_merge;
    t_result w_res;
    logic    w_fire;
    logic    w_push;
    logic    w_buf_ready;

    assign w_fire = i_in.valid && w_buf_ready;
    assign i_in.ready = w_buf_ready;

    // message blocks in the cipher's byte order: byte 0 in the low bits
    assign w_m0   = {i_in.in_w1, i_in.in_w0};
    assign w_m1   = {i_in.in_w3, i_in.in_w2};
    assign w_load = w_m0;

    aegis128l_merge u_merge (
        .i_state (r_state),
        .i_mode  (i_in.mode),
        .i_m0    (w_m0),
        .i_m1    (w_m1),
        .o_merge (w_merge)
    );

    // eight lanes, each takes the AES round of its predecessor block
    for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_lane
        t_block w_msg;
        if (j == 0) begin : g_m0
            assign w_msg = w_merge.fb_m0;
        end else if (j == 4) begin : g_m1
            assign w_msg = w_merge.fb_m1;
        end else begin : g_zero
            assign w_msg = '0;
        end
        aegis128l_lane u_lane (
            .i_src  (r_state[(j + NUM_BLOCKS - 1) % NUM_BLOCKS]),
            .i_self (r_state[j]),
            .i_msg  (w_msg),
            .o_next (w_lane_next[j])
        );
    end

    // read block: low half, high half, upper words zero
    always_comb begin
        w_res  = w_merge.result;
        w_push = w_fire && w_merge.has_result;
        if (i_in.mode == MODE_READ) begin
            w_res  = '0;
            w_res.out_w0 = r_state[i_in.block_index][WORD_W-1:0];
            w_res.out_w1 = r_state[i_in.block_index][BLOCK_W-1:WORD_W];
            w_push = w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_fire) begin
            if (w_merge.do_update) begin
                r_state <= w_lane_next;
            end else if (i_in.mode == MODE_LOAD) begin
                r_state[i_in.block_index] <= w_load;
            end
        end
    end

    aegis128l_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_ready (w_buf_ready),
        .o_out   (o_out)
    );

endmodule
